// ===== hw/rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the seven-segment scan driver.
// Used by ssd_ctrl, ssd_datapath and seven_segment_scan_driver_unit; depends on nothing.
package ssd_pkg;

   // Command codes of the request word.
   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_NUMBER = 2'd1,
      CMD_SET_SYMBOL = 2'd2,
      CMD_CLEAR      = 2'd3
   } cmd_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NUMBER,
      ST_SYMBOL,
      ST_CLEAR,
      ST_TICK
   } state_type;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ANODE_MASK  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MODES = 1'b1;

   // Drive modes of a select line; mode three behaves as direct drive.
   localparam logic [1:0] DRIVE_PNP = 2'd1;
   localparam logic [1:0] DRIVE_NPN = 2'd2;

   localparam int SEG_W      = 7;
   localparam int SEL_W      = 4;
   localparam int ACT_W      = 2;
   localparam int VALUE_W    = 16;
   localparam int POSITION_W = 3;
   localparam int SYMBOL_W   = 4;
   localparam logic [SYMBOL_W-1:0] BLANK_SYMBOL = 4'd10;

   // Division by ten through a reciprocal: exact for all 16-bit values.
   localparam logic [VALUE_W-1:0] DIV10_MUL   = 16'd52429;
   localparam int                 DIV10_SHIFT = 19;

   typedef struct packed {
      cmd_type                 cmd;
      logic [POSITION_W-1:0]   position;
      logic [VALUE_W-1:0]      value;
   } req_word_type;

   typedef struct packed {
      logic [SEG_W-1:0] segment_levels;
      logic [SEL_W-1:0] select_levels;
      logic [ACT_W-1:0] active_display;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic sym_wr;
      logic dig_wr;
      logic clr;
      logic tick;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic number_done;
   } dp_sts_type;

   // Segment pattern of a symbol; codes above nine give a blank display.
   function automatic logic [SEG_W-1:0] glyph(input logic [SYMBOL_W-1:0] sym);
      logic [SEG_W-1:0] pat;
      case (sym)
         4'd0:    pat = 7'h3f;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5b;
         4'd3:    pat = 7'h4f;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6d;
         4'd6:    pat = 7'h7d;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7f;
         4'd9:    pat = 7'h6f;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

endpackage

// ===== hw/rtl/ssd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the seven-segment scan driver.
// Depends on ssd_pkg; drives the command word of ssd_datapath.
module ssd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ssd_pkg::cmd_type    cmd,
   input  ssd_pkg::dp_sts_type sts,
   output ssd_pkg::dp_cmd_type dp_cmd,
   output logic                busy
);

   ssd_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssd_pkg::ST_IDLE: begin
            if (start) begin
               case (cmd)
                  ssd_pkg::CMD_TICK:       state_in = ssd_pkg::ST_TICK;
                  ssd_pkg::CMD_SET_NUMBER: state_in = ssd_pkg::ST_NUMBER;
                  ssd_pkg::CMD_SET_SYMBOL: state_in = ssd_pkg::ST_SYMBOL;
                  ssd_pkg::CMD_CLEAR:      state_in = ssd_pkg::ST_CLEAR;
                  default:                 state_in = ssd_pkg::ST_IDLE;
               endcase
            end
         end
         ssd_pkg::ST_NUMBER: begin
            if (sts.number_done) begin
               state_in = ssd_pkg::ST_IDLE;
            end
         end
         ssd_pkg::ST_SYMBOL: state_in = ssd_pkg::ST_IDLE;
         ssd_pkg::ST_CLEAR:  state_in = ssd_pkg::ST_IDLE;
         ssd_pkg::ST_TICK:   state_in = ssd_pkg::ST_IDLE;
         default:            state_in = ssd_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands for each state.
   always_comb begin
      dp_cmd = '0;
      busy   = 1'b1;
      case (state_ff)
         ssd_pkg::ST_IDLE: begin
            busy        = 1'b0;
            dp_cmd.load = start;
         end
         ssd_pkg::ST_NUMBER: dp_cmd.dig_wr = !sts.number_done;
         ssd_pkg::ST_SYMBOL: dp_cmd.sym_wr = 1'b1;
         ssd_pkg::ST_CLEAR:  dp_cmd.clr    = 1'b1;
         ssd_pkg::ST_TICK:   dp_cmd.tick   = 1'b1;
         default:            busy          = 1'b1;
      endcase
   end

endmodule

// ===== hw/rtl/ssd_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the seven-segment scan driver: pattern store, digit splitter,
// scan pointer, configuration registers and result register. Depends on ssd_pkg.
module ssd_datapath #(
   parameter int NUM_DISPLAYS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssd_pkg::req_word_type                req_word,
   input  ssd_pkg::dp_cmd_type                  dp_cmd,
   output ssd_pkg::dp_sts_type                  sts,
   input  logic                                 csr_write_en,
   input  logic [ssd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_strobe,
   output ssd_pkg::rsp_word_type                rsp_word
);

   localparam int PTR_W = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;
   localparam int POS_W = ssd_pkg::POSITION_W + 1;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(NUM_DISPLAYS);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(NUM_DISPLAYS - 1);

   logic [3:0]                      anode_ff;
   logic [7:0]                      drive_ff;
   logic [ssd_pkg::VALUE_W-1:0]     op_val_ff, op_val_in;
   logic [POS_W-1:0]                op_pos_ff, op_pos_in;
   logic [ssd_pkg::SEG_W-1:0]       pat_ff [NUM_DISPLAYS];
   logic [ssd_pkg::SEG_W-1:0]       pat_in [NUM_DISPLAYS];
   logic [PTR_W-1:0]                ptr_ff, ptr_in;
   logic                            strobe_ff;
   ssd_pkg::rsp_word_type           rsp_ff, rsp_in;

   logic                            pos_in_range;
   logic [PTR_W-1:0]                wr_idx;
   logic [31:0]                     prod;
   logic [ssd_pkg::VALUE_W-1:0]     quot;
   logic [ssd_pkg::VALUE_W-1:0]     quot_x10;
   logic [ssd_pkg::SYMBOL_W-1:0]    rem_digit;
   logic [ssd_pkg::SYMBOL_W-1:0]    sym_sat;
   logic [2:0]                      ptr_wide;
   logic                            act_anode;
   logic [ssd_pkg::SEG_W-1:0]       act_pat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         anode_ff <= '0;
         drive_ff <= '0;
      end else if (csr_write_en) begin
         if (csr_index == ssd_pkg::CSR_ANODE_MASK) begin
            anode_ff <= csr_wdata[3:0];
         end else if (csr_index == ssd_pkg::CSR_DRIVE_MODES) begin
            drive_ff <= csr_wdata;
         end
      end
   end

   // Divide the working number by ten; the remainder is the next digit.
   assign prod      = 32'(op_val_ff) * 32'(ssd_pkg::DIV10_MUL);
   assign quot      = ssd_pkg::VALUE_W'(prod >> ssd_pkg::DIV10_SHIFT);
   assign quot_x10  = (quot << 3) + (quot << 1);
   assign rem_digit = ssd_pkg::SYMBOL_W'(op_val_ff - quot_x10);

   assign pos_in_range    = op_pos_ff < POS_LIMIT;
   assign wr_idx          = op_pos_ff[PTR_W-1:0];
   assign sts.number_done = (op_val_ff == '0) || !pos_in_range;

   // Symbols above ten saturate to blank.
   assign sym_sat = (op_val_ff > 16'(ssd_pkg::BLANK_SYMBOL)) ?
                    ssd_pkg::BLANK_SYMBOL : op_val_ff[ssd_pkg::SYMBOL_W-1:0];

   // Operand registers: loaded on accept, stepped once per digit.
   always_comb begin
      op_val_in = op_val_ff;
      op_pos_in = op_pos_ff;
      if (dp_cmd.load) begin
         op_val_in = req_word.value;
         op_pos_in = POS_W'(req_word.position);
      end else if (dp_cmd.dig_wr) begin
         op_val_in = quot;
         op_pos_in = op_pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      op_val_ff <= op_val_in;
      op_pos_ff <= op_pos_in;
   end

   // Pattern store updates.
   always_comb begin
      for (int i = 0; i < NUM_DISPLAYS; i++) begin
         pat_in[i] = pat_ff[i];
      end
      if (dp_cmd.clr) begin
         for (int i = 0; i < NUM_DISPLAYS; i++) begin
            pat_in[i] = '0;
         end
      end else if (dp_cmd.sym_wr && pos_in_range) begin
         pat_in[wr_idx] = ssd_pkg::glyph(sym_sat);
      end else if (dp_cmd.dig_wr) begin
         pat_in[wr_idx] = ssd_pkg::glyph(rem_digit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DISPLAYS; i++) begin
            pat_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_DISPLAYS; i++) begin
            pat_ff[i] <= pat_in[i];
         end
      end
   end

   // Next scan position, wrapping after the last display.
   assign ptr_in    = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
   assign ptr_wide  = 3'(ptr_in);
   assign act_anode = (ptr_wide < 3'd4) && anode_ff[ptr_wide[1:0]];
   assign act_pat   = pat_ff[ptr_in];

   // Result word for the display that the tick switches on.
   always_comb begin
      logic [1:0] mode;
      logic       lvl;
      rsp_in                = '0;
      rsp_in.segment_levels = act_anode ? ~act_pat : act_pat;
      rsp_in.active_display = ptr_wide[1:0];
      for (int d = 0; d < ssd_pkg::SEL_W; d++) begin
         mode = drive_ff[2*d +: 2];
         if (mode == ssd_pkg::DRIVE_PNP) begin
            lvl = 1'b0;
         end else if (mode == ssd_pkg::DRIVE_NPN) begin
            lvl = 1'b1;
         end else begin
            lvl = anode_ff[d];
         end
         if (ptr_wide != 3'(d)) begin
            lvl = !lvl;
         end
         rsp_in.select_levels[d] = (d < NUM_DISPLAYS) ? lvl : 1'b0;
      end
   end

   // Scan pointer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dp_cmd.tick;
         if (dp_cmd.tick) begin
            ptr_ff <= ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.tick) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== hw/rtl/seven_segment_scan_driver_unit.sv =====
`timescale 1ns / 1ps
// Top level of the seven-segment scan driver: controller plus datapath.
// Depends on ssd_pkg, ssd_ctrl and ssd_datapath.
//
// Usage:
//   A command word on req_word is taken at a clock edge where start is high
//   and busy is low. Commands are tick, set_number, set_symbol and clear.
//   Only tick produces a result word: rsp_strobe is high for one cycle, after the
//   tick has passed the controller's tick state and the result register, with
//   segment levels, select levels and the index of the display now switched on.
//   The receiver cannot stall; the result is simply present for that one cycle.
//   Busy: tick, set_symbol and clear keep busy high while the controller is in
//   that command's state; set_number keeps it high while the digit loop, one
//   divide-by-ten step per cycle, writes digits, until the datapath reports
//   number_done (the number is zero or the position is past the last display).
//   Configuration: csr_write_en writes csr_wdata into anode_mask (index 0) or
//   drive_modes (index 1) at once; write only while the block is idle.
//   Reset (synchronous, active high) blanks all displays, zeroes the scan
//   pointer and both configuration registers, and returns the controller to
//   idle. No result is pending after reset.
module seven_segment_scan_driver_unit #(
   parameter int NUM_DISPLAYS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ssd_pkg::req_word_type            req_word,
   output logic                             rsp_strobe,
   output ssd_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_write_en,
   input  logic [ssd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ssd_pkg::dp_cmd_type dp_cmd;
   ssd_pkg::dp_sts_type dp_sts;

   // Sequencer.
   ssd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (req_word.cmd),
      .sts    (dp_sts),
      .dp_cmd (dp_cmd),
      .busy   (busy)
   );

   // Storage and arithmetic.
   ssd_datapath #(
      .NUM_DISPLAYS (NUM_DISPLAYS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_word     (req_word),
      .dp_cmd       (dp_cmd),
      .sts          (dp_sts),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_strobe   (rsp_strobe),
      .rsp_word     (rsp_word)
   );

   // A tick taken in idle yields a result word once it has passed the tick state and the result register.
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.cmd == ssd_pkg::CMD_TICK) |=> ##1 rsp_strobe)
      else $error("tick did not produce a result word");

   // A result word follows a busy cycle and lasts one cycle.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without preceding work");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // Only tick commands lead to a result word.
   a_strobe_only_tick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.cmd != ssd_pkg::CMD_TICK) |=> ##1 !rsp_strobe)
      else $error("result word after a non-tick command");

endmodule
